### rtl/torq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_pkg: shared types for the time-ordered release queue
// Entry layout, result bundle and operation codes used by the sequencer and the top level.
// ----------------------------------------------------------------------------
package torq_pkg;

    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int OCC_W   = 5;
    localparam int ENTRY_W = KEY_W + TAG_W;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             released;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

### rtl/torq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_ram: generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module torq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/torq_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_walk: queue sequencer and shared key comparator
// Keeps the entries as a ring in the RAM, walks it from the tail for inserts
// and checks the head for releases, one compare per cycle.
// ----------------------------------------------------------------------------
module torq_walk
    import torq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [KEY_W-1:0]         time_value,
    input  logic [TAG_W-1:0]         entry_tag,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output entry_t                   ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  entry_t                   ram_rdata,
    output logic                     res_valid,
    output res_t                     res,
    input  logic                     res_take
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;
    localparam logic [1:0] S_DLV  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    res_t             res_reg, res_next;
    logic [PW-1:0]    prev_cur;

    function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
        return (p == '0) ? LAST : p - PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OCC_W-1:0];
    endfunction

    assign prev_cur = ptr_prev(cur_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '{key: key_reg, tag: tag_reg};
        // read ahead one slot below the entry now arriving
        ram_raddr  = ptr_prev(prev_cur);

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (opcode == OP_RELEASE) ? head_reg : ptr_prev(tail_reg);
                if (in_valid)
                begin
                    key_next = time_value;
                    tag_next = entry_tag;
                    res_next = '0;
                    res_next.occupancy = occ_of(count_reg);
                    if (opcode == OP_RELEASE)
                    begin
                        state_next = (count_reg == '0) ? S_DLV : S_REL;
                    end
                    else if (count_reg == FULL)
                    begin
                        res_next.dropped = 1'b1;
                        state_next = S_DLV;
                    end
                    else
                    begin
                        cur_next   = tail_reg;
                        left_next  = count_reg;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                ram_we = 1'b1;
                if (left_reg == '0 || ram_rdata.key <= key_reg)
                begin
                    // slot found: place the new entry
                    tail_next  = ptr_next(tail_reg);
                    count_next = count_reg + CW'(1);
                    res_next.occupancy = occ_of(count_reg + CW'(1));
                    state_next = S_DLV;
                end
                else
                begin
                    // later entry: move it up one slot
                    ram_wdata = ram_rdata;
                    cur_next  = prev_cur;
                    left_next = left_reg - CW'(1);
                end
            end
            S_REL:
            begin
                if (ram_rdata.key <= key_reg)
                begin
                    head_next  = ptr_next(head_reg);
                    count_next = count_reg - CW'(1);
                    res_next.released  = 1'b1;
                    res_next.tag       = ram_rdata.tag;
                    res_next.key       = ram_rdata.key;
                    res_next.occupancy = occ_of(count_reg - CW'(1));
                end
                state_next = S_DLV;
            end
            S_DLV:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        cur_reg  <= cur_next;
        key_reg  <= key_next;
        tag_reg  <= tag_next;
        res_reg  <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DLV);
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count beyond capacity");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (left_reg <= count_reg))
        else $error("walk runs past the stored entries");

    a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_reg.released && res_reg.dropped))
        else $error("result both released and dropped");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL && ram_rdata.key <= key_reg)
            |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not reduce the count");

endmodule

### rtl/time_ordered_release_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_release_queue: sorted queue of time-tagged commands
// Holds up to DEPTH entries ordered by release time and pops the head when due.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat is an insert (opcode 0,
//   time_value and entry_tag) or a release (opcode 1, time_value = now).
//   Output channel (out_valid / out_stall): exactly one result beat per
//   input beat, in order.
//   Timing: an insert walks the ring from the tail, one stored entry per
//   cycle through the single key comparator and the RAM read port, and
//   holds in_stall while it moves the later entries up; a release or a
//   dropped insert holds it too, so a new beat is taken only once the
//   sequencer is idle again. The result passes from the sequencer through
//   the output register.
//   Reset empties the queue at once; the RAM contents are not cleared.
//   When the receiver stalls, the output beat holds; one further item may be
//   accepted and worked, and its result waits in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
module time_ordered_release_queue
    import torq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             opcode,
    input  logic [KEY_W-1:0] time_value,
    input  logic [TAG_W-1:0] entry_tag,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             released,
    output logic [TAG_W-1:0] released_tag,
    output logic [KEY_W-1:0] released_time,
    output logic             insert_dropped,
    output logic [OCC_W-1:0] occupancy
);

    localparam int PW = $clog2(DEPTH);

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    logic          res_valid;
    logic          res_take;
    res_t          res;
    logic          out_valid_reg;
    res_t          out_reg;

    // entry store: key and tag share one word
    torq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    torq_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .time_value (time_value),
        .entry_tag  (entry_tag),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // take a finished result whenever the output register is free or draining
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign released       = out_reg.released;
    assign released_tag   = out_reg.tag;
    assign released_time  = out_reg.key;
    assign insert_dropped = out_reg.dropped;
    assign occupancy      = out_reg.occupancy;

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !released) |-> (released_tag == '0 && released_time == '0))
        else $error("payload not cleared on a result without release");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_take)
        else $error("stalled output beat overwritten");

    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid_reg)
        else $error("taken result not presented");

endmodule
